// ===== sv/assert_macros.svh =====
// Assertion helpers for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PSQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define PSQ_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define PSQ_ASSERT(label, clk, rst, prop)
`define PSQ_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== sv/psq_pkg.sv =====
package psq_pkg;

   localparam int MAX_PROCESSES   = 16;
   localparam int TIME_BITS       = 16;
   localparam int SLOT_BITS       = $clog2(MAX_PROCESSES);

   // fixed field widths
   localparam int SLOT_FIELD_BITS = 4;
   localparam int IN_TIME_BITS    = 16;
   localparam int PRIO_BITS       = 8;
   localparam int CLOCK_BITS      = 21;
   localparam int QUANTUM_BITS    = 16;
   localparam int COUNT_BITS      = 5;

   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   // shared add/subtract unit is one bit wider than its widest operand
   localparam int UNIT_BITS = ((TIME_BITS > CLOCK_BITS) ? TIME_BITS : CLOCK_BITS) + 1;

   localparam logic [CLOCK_BITS-1:0] TIME_LIMIT = '1;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } command_type;

   typedef enum logic {
      REG_QUANTUM       = 1'b0,
      REG_PROCESS_COUNT = 1'b1
   } reg_index_type;

endpackage

// ===== sv/psq_req_if.sv =====
interface psq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 command;
   logic [psq_pkg::SLOT_FIELD_BITS-1:0]  slot;
   logic [psq_pkg::IN_TIME_BITS-1:0]     arrival;
   logic [psq_pkg::IN_TIME_BITS-1:0]     burst;
   logic [psq_pkg::PRIO_BITS-1:0]        priority_req;

   modport source (output valid, command, slot, arrival, burst, priority_req, input ready);
   modport sink   (input valid, command, slot, arrival, burst, priority_req, output ready);
endinterface

// ===== sv/psq_rsp_if.sv =====
interface psq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [psq_pkg::SLOT_FIELD_BITS-1:0]  slice_process;
   logic [psq_pkg::CLOCK_BITS-1:0]       slice_start;
   logic [psq_pkg::CLOCK_BITS-1:0]       slice_end;
   logic                                 finished;
   logic [psq_pkg::CLOCK_BITS-1:0]       waiting_time;
   logic [psq_pkg::CLOCK_BITS-1:0]       turnaround_time;
   logic                                 all_done;

   modport source (output valid, slice_process, slice_start, slice_end, finished,
                   waiting_time, turnaround_time, all_done, input ready);
   modport sink   (input valid, slice_process, slice_start, slice_end, finished,
                   waiting_time, turnaround_time, all_done, output ready);
endinterface

// ===== sv/priority_quantum_scheduler_unit.sv =====
// Channel   Dir  Role                       Transaction
// req       in   load slot / step command   valid & ready at rising edge
// rsp       out  one slice report per step  valid & ready at rising edge
// csr       in   APB quantum, process_count write at psel & penable & pwrite
//
// Load: accepted while idle. Step: a scan of all MAX_PROCESSES slots (one slot per
// cycle through the shared compare path), decide, then run, advance, turnaround and
// emit on the shared add/subtract unit; a step that must jump time to the next
// arrival rescans. A step with nothing pending goes from decide straight to emit.
// Reset (synchronous) sets quantum and count to 1, clears pending marks, time, state.
// A held result stalls the following step only in its emit state; loads go on.
`include "assert_macros.svh"

module priority_quantum_scheduler_unit (
   input  logic                                clock,
   input  logic                                reset,
   psq_req_if.sink                             req,
   psq_rsp_if.source                           rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [psq_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [psq_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [psq_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   localparam int NP = psq_pkg::MAX_PROCESSES;
   localparam int SB = psq_pkg::SLOT_BITS;
   localparam int TB = psq_pkg::TIME_BITS;
   localparam int CB = psq_pkg::CLOCK_BITS;
   localparam int UB = psq_pkg::UNIT_BITS;
   localparam int PB = psq_pkg::PRIO_BITS;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SCAN    = 7'b0000010,
      ST_DECIDE  = 7'b0000100,
      ST_RUN     = 7'b0001000,
      ST_ADVANCE = 7'b0010000,
      ST_TAT     = 7'b0100000,
      ST_EMIT    = 7'b1000000
   } state_type;

   // ---------------- configuration ----------------
   logic [psq_pkg::QUANTUM_BITS-1:0] quantum_ff;
   logic [psq_pkg::COUNT_BITS-1:0]   count_ff;
   logic                             csr_write;
   psq_pkg::reg_index_type           csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = psq_pkg::reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= psq_pkg::QUANTUM_BITS'(1);
         count_ff   <= psq_pkg::COUNT_BITS'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            psq_pkg::REG_QUANTUM:       quantum_ff <= pwdata[psq_pkg::QUANTUM_BITS-1:0];
            psq_pkg::REG_PROCESS_COUNT: count_ff   <= pwdata[psq_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         psq_pkg::REG_QUANTUM:       prdata = psq_pkg::CSR_DATA_BITS'(quantum_ff);
         psq_pkg::REG_PROCESS_COUNT: prdata = psq_pkg::CSR_DATA_BITS'(count_ff);
         default:                    prdata = '0;
      endcase
   end

   // ---------------- slot tables ----------------
   logic [TB-1:0] arr_ff [NP];
   logic [TB-1:0] bur_ff [NP];
   logic [PB-1:0] pri_ff [NP];
   logic [TB-1:0] rem_ff [NP];
   logic [NP-1:0] pending_ff;

   // ---------------- sequencer registers ----------------
   state_type     state_ff, state_in;
   logic [SB-1:0] idx_ff, idx_in;
   logic [SB-1:0] sel_ff, sel_in;
   logic          found_ff, found_in;
   logic [PB-1:0] best_ff, best_in;
   logic          nfound_ff, nfound_in;
   logic [TB-1:0] next_ff, next_in;
   logic [CB-1:0] time_ff, time_in;
   logic [CB-1:0] start_ff, start_in;
   logic [CB-1:0] end_ff, end_in;
   logic [CB-1:0] tat_ff, tat_in;
   logic [TB-1:0] run_ff, run_in;
   logic          fin_ff, fin_in;

   logic                                rsp_valid_ff;
   logic [psq_pkg::SLOT_FIELD_BITS-1:0] rsp_process_ff;
   logic [CB-1:0]                       rsp_start_ff;
   logic [CB-1:0]                       rsp_end_ff;
   logic                                rsp_finished_ff;
   logic [CB-1:0]                       rsp_waiting_ff;
   logic [CB-1:0]                       rsp_turnaround_ff;
   logic                                rsp_all_done_ff;

   // ---------------- datapath ----------------
   logic                            req_fire;
   logic                            rsp_load;
   logic                            tbl_load;
   logic [SB-1:0]                   load_addr;
   logic                            rem_we;
   logic [TB-1:0]                   rem_wdata;
   logic                            pend_clear;
   logic [SB-1:0]                   rd_addr;
   logic [TB-1:0]                   rd_arr;
   logic [TB-1:0]                   rd_bur;
   logic [PB-1:0]                   rd_pri;
   logic [TB-1:0]                   rd_rem;
   logic [psq_pkg::COUNT_BITS-1:0]  active_n;
   logic [NP-1:0]                   active_mask;
   logic [psq_pkg::QUANTUM_BITS-1:0] q_eff;
   logic [UB-1:0]                   unit_a, unit_b, unit_res;
   logic                            unit_sub;
   logic                            unit_borrow;
   logic [CB-1:0]                   wt_value;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign load_addr = SB'(req.slot);
   assign tbl_load  = req_fire && (req.command == psq_pkg::CMD_LOAD) &&
                      (32'(req.slot) < NP);

   assign active_n = (32'(count_ff) > NP) ? psq_pkg::COUNT_BITS'(NP) : count_ff;
   always_comb begin
      for (int i = 0; i < NP; i++) active_mask[i] = (i < int'(active_n));
   end

   assign q_eff = (quantum_ff == '0) ? psq_pkg::QUANTUM_BITS'(1) : quantum_ff;

   // single table read port: scan index while scanning, chosen slot afterwards
   assign rd_addr = (state_ff == ST_SCAN) ? idx_ff : sel_ff;
   assign rd_arr  = arr_ff[rd_addr];
   assign rd_bur  = bur_ff[rd_addr];
   assign rd_pri  = pri_ff[rd_addr];
   assign rd_rem  = rem_ff[rd_addr];

   // shared add/subtract unit; operands stay below its MSB, so MSB is the borrow
   assign unit_res    = unit_sub ? (unit_a - unit_b) : (unit_a + unit_b);
   assign unit_borrow = unit_res[UB-1];
   assign wt_value    = unit_borrow ? '0 : CB'(unit_res);

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      sel_in     = sel_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      nfound_in  = nfound_ff;
      next_in    = next_ff;
      time_in    = time_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      tat_in     = tat_ff;
      run_in     = run_ff;
      fin_in     = fin_ff;
      unit_a     = '0;
      unit_b     = '0;
      unit_sub   = 1'b0;
      rem_we     = 1'b0;
      rem_wdata  = '0;
      pend_clear = 1'b0;
      rsp_load   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req.command == psq_pkg::CMD_STEP) begin
               idx_in    = '0;
               found_in  = 1'b0;
               nfound_in = 1'b0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (active_mask[idx_ff] && pending_ff[idx_ff]) begin
               if (!nfound_ff || rd_arr < next_ff) begin
                  next_in   = rd_arr;
                  nfound_in = 1'b1;
               end
               if (UB'(rd_arr) <= UB'(time_ff) && (!found_ff || rd_pri < best_ff)) begin
                  sel_in   = idx_ff;
                  best_in  = rd_pri;
                  found_in = 1'b1;
               end
            end
            if (idx_ff == SB'(NP - 1)) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + SB'(1);
            end
         end
         ST_DECIDE: begin
            priority if (found_ff) begin
               state_in = ST_RUN;
            end else if (nfound_ff) begin
               // nothing ready: jump to the earliest pending arrival and rescan
               if (UB'(next_ff) > UB'(time_ff)) time_in = CB'(next_ff);
               idx_in    = '0;
               found_in  = 1'b0;
               nfound_in = 1'b0;
               state_in  = ST_SCAN;
            end else begin
               sel_in   = '0;
               start_in = '0;
               end_in   = '0;
               fin_in   = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_RUN: begin
            unit_a   = UB'(rd_rem);
            unit_b   = UB'(q_eff);
            unit_sub = 1'b1;
            start_in = time_ff;
            rem_we   = 1'b1;
            if (!unit_borrow && unit_res != '0) begin
               rem_wdata = TB'(unit_res);
               run_in    = TB'(q_eff);
               fin_in    = 1'b0;
            end else begin
               rem_wdata  = '0;
               run_in     = rd_rem;
               fin_in     = 1'b1;
               pend_clear = 1'b1;
            end
            state_in = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            unit_a = UB'(time_ff);
            unit_b = UB'(run_ff);
            if (unit_res > UB'(psq_pkg::TIME_LIMIT)) begin
               time_in = psq_pkg::TIME_LIMIT;
               end_in  = psq_pkg::TIME_LIMIT;
            end else begin
               time_in = CB'(unit_res);
               end_in  = CB'(unit_res);
            end
            state_in = ST_TAT;
         end
         ST_TAT: begin
            unit_a   = UB'(end_ff);
            unit_b   = UB'(rd_arr);
            unit_sub = 1'b1;
            tat_in   = unit_borrow ? '0 : CB'(unit_res);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            unit_a   = UB'(tat_ff);
            unit_b   = UB'(rd_bur);
            unit_sub = 1'b1;
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (tbl_load) begin
         arr_ff[load_addr] <= TB'(req.arrival);
         bur_ff[load_addr] <= TB'(req.burst);
         pri_ff[load_addr] <= req.priority_req;
         rem_ff[load_addr] <= TB'(req.burst);
      end else if (rem_we) begin
         rem_ff[sel_ff] <= rem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (tbl_load) begin
         pending_ff[load_addr] <= (req.burst != '0);
      end else if (pend_clear) begin
         pending_ff[sel_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         time_ff  <= '0;
      end else begin
         state_ff <= state_in;
         time_ff  <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      sel_ff    <= sel_in;
      found_ff  <= found_in;
      best_ff   <= best_in;
      nfound_ff <= nfound_in;
      next_ff   <= next_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      tat_ff    <= tat_in;
      run_ff    <= run_in;
      fin_ff    <= fin_in;
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_process_ff    <= psq_pkg::SLOT_FIELD_BITS'(sel_ff);
         rsp_start_ff      <= start_ff;
         rsp_end_ff        <= end_ff;
         rsp_finished_ff   <= fin_ff;
         rsp_waiting_ff    <= fin_ff ? wt_value : '0;
         rsp_turnaround_ff <= fin_ff ? tat_ff : '0;
         rsp_all_done_ff   <= ~|(pending_ff & active_mask);
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.slice_process   = rsp_process_ff;
   assign rsp.slice_start     = rsp_start_ff;
   assign rsp.slice_end       = rsp_end_ff;
   assign rsp.finished        = rsp_finished_ff;
   assign rsp.waiting_time    = rsp_waiting_ff;
   assign rsp.turnaround_time = rsp_turnaround_ff;
   assign rsp.all_done        = rsp_all_done_ff;

   // ---------------- assertions ----------------
   `PSQ_ASSERT(a_unfinished_zero, clock, reset, rsp_valid_ff && !rsp_finished_ff |-> rsp_waiting_ff == '0 && rsp_turnaround_ff == '0)
   `PSQ_ASSERT(a_slice_order, clock, reset, rsp_valid_ff |-> rsp_end_ff >= rsp_start_ff && rsp_turnaround_ff <= rsp_end_ff && rsp_waiting_ff <= rsp_turnaround_ff)
   `PSQ_ASSERT(a_time_monotonic, clock, reset, !$past(reset) |-> time_ff >= $past(time_ff))
   `PSQ_NEVER(a_finished_still_pending, clock, reset, state_ff == ST_EMIT && fin_ff && pending_ff[sel_ff])

endmodule
